### design/rfde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfde_pkg
// Shared types and constants of the RGB frame delta encoder.
// ----------------------------------------------------------------------------
package rfde_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_WIDTH    = 2'd0,
		CFG_HEIGHT   = 2'd1,
		CFG_INTERVAL = 2'd2,
		CFG_LEVEL    = 2'd3
	} cfg_idx_t;

	// frame type codes, low nibble of the first header byte
	localparam logic [3:0] TYPE_KEY   = 4'h3;
	localparam logic [3:0] TYPE_DELTA = 4'h2;
	localparam logic [7:0] HDR_SECOND = 8'd8;

	// tuser bit positions
	localparam int TUSER_W = 3;
	localparam int TU_HDR  = 0;
	localparam int TU_KEY  = 1;
	localparam int TU_FEND = 2;

	// front-to-back queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// one classified pixel, ready for serialization
	typedef struct packed {
		logic        start;  // first pixel of frame: send header first
		logic        key;    // frame coded as keyframe
		logic        fend;   // last pixel of frame
		logic [7:0]  hdr;    // first header byte
		logic [23:0] data;   // R 23:16, G 15:8, B 7:0 (raw or delta)
	} rfde_entry_t;

endpackage
`default_nettype wire

### design/rgb_frame_delta_encoder.sv
`default_nettype none
// Path: the first output word of a pixel passes stage 1 (with store read), then
//   the queue, then the output register; an earlier pixel or a stalled sink holds it.
// Output: three colour words per pixel, two header words first on a frame start; one word
//   per cycle unless stalled. Input is taken back to back while the queue has room.
// Reset: control state clears, the first frame after reset is a keyframe;
//   the previous-frame store is not cleared and holds no defined contents.
// ----------------------------------------------------------------------------
// rgb_frame_delta_encoder
// Inter-frame delta coder for padded RGB frames: per pixel emits R, G, B
// as raw bytes on keyframes or as differences to the previous frame.
// ----------------------------------------------------------------------------
module rgb_frame_delta_encoder
	import rfde_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [29:0]        cfg_data,
	// pixel stream in
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [31:0]        s_tdata,   // pixel_word
	// coded stream out
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,   // out_byte
	output logic [TUSER_W-1:0]      m_tuser,   // is_header, is_keyframe, frame_end
	output logic                    m_tlast    // last word of this pixel
);

	// configuration registers
	logic [9:0]  width_q;
	logic [9:0]  height_q;
	logic [29:0] interval_q;
	logic [3:0]  level_q;

	// front-to-back link
	logic            push;
	rfde_entry_t     push_entry;
	logic            pop;
	logic            head_valid;
	rfde_entry_t     head;
	logic [Q_CW-1:0] q_count;

	// The user writes config only while idle (not enforced), so the front reads these live.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 10'd512;
			height_q   <= 10'd512;
			interval_q <= 30'd0;
			level_q    <= 4'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:    width_q    <= cfg_data[9:0];
				CFG_HEIGHT:   height_q   <= cfg_data[9:0];
				CFG_INTERVAL: interval_q <= cfg_data;
				CFG_LEVEL:    level_q    <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Front: scan position, keyframe choice, store read/write, delta.
	rfde_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.image_width       (width_q),
		.image_height      (height_q),
		.keyframe_interval (interval_q),
		.compression_level (level_q),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.q_count           (q_count),
		.push              (push),
		.push_entry        (push_entry)
	);

	// Four-deep queue decouples pixel intake from byte output.
	rfde_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	// Back: two header words on the first pixel of a frame, then three colour words per pixel.
	rfde_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

### design/rfde_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfde_front
// Scan position tracking, keyframe decision, previous-frame store and
// delta computation. Pushes one classified pixel per accepted word.
// ----------------------------------------------------------------------------
module rfde_front
	import rfde_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [9:0]        image_width,
	input  wire logic [9:0]        image_height,
	input  wire logic [29:0]       keyframe_interval,
	input  wire logic [3:0]        compression_level,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [31:0]       s_tdata,
	input  wire logic [Q_CW-1:0]   q_count,
	output logic                   push,
	output rfde_entry_t            push_entry
);

	localparam int STORE_W = (MAX_WIDTH + 3) / 4 * 4;
	localparam int STORE_H = (MAX_HEIGHT + 3) / 4 * 4;
	localparam int DEPTH   = STORE_W * STORE_H;
	localparam int AW      = $clog2(DEPTH);
	localparam int BW      = $clog2(DEPTH + 1);
	localparam int CW      = $clog2(STORE_W + 1);
	localparam int RW      = $clog2(STORE_H + 1);

	// scan state
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [BW-1:0] base_q;    // row_q * STORE_W
	logic [29:0]   fsk_q;
	logic          force_q;
	logic          key_q;

	// stage 1
	logic          v_s1;
	logic          start_s1;
	logic          key_s1;
	logic          fend_s1;
	logic [7:0]    hdr_s1;
	logic [23:0]   raw_s1;
	logic [23:0]   prev_s1;

	logic [23:0]   mem [DEPTH];

	logic [CW-1:0] w, pw;
	logic [RW-1:0] h, ph;
	logic [CW:0]   w_p3;
	logic [RW:0]   h_p3;
	logic          accept;
	logic          wrap_c, wrap_r, start, take_key, key_a, pad, fend;
	logic [CW-1:0] col_a, col_n;
	logic [RW-1:0] row_b, row_a, row_n;
	logic [BW-1:0] base_b, base_a, base_n;
	logic [AW-1:0] addr;
	logic [23:0]   raw;

	// dimension clamp and pad-to-4
	always_comb begin
		if (image_width == 10'd0) begin
			w = CW'(1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w = CW'(MAX_WIDTH);
		end else begin
			w = CW'(image_width);
		end
		if (image_height == 10'd0) begin
			h = RW'(1);
		end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			h = RW'(MAX_HEIGHT);
		end else begin
			h = RW'(image_height);
		end
		w_p3 = {1'b0, w} + (CW + 1)'(3);
		h_p3 = {1'b0, h} + (RW + 1)'(3);
		pw   = CW'(w_p3 & ~(CW + 1)'(3));
		ph   = RW'(h_p3 & ~(RW + 1)'(3));
	end

	// one scan step; the wrap in front covers dimensions shrunk mid-frame
	always_comb begin
		wrap_c   = col_q >= pw;
		col_a    = wrap_c ? '0 : col_q;
		row_b    = wrap_c ? row_q + RW'(1) : row_q;
		base_b   = wrap_c ? base_q + BW'(STORE_W) : base_q;
		wrap_r   = row_b >= ph;
		row_a    = wrap_r ? '0 : row_b;
		base_a   = wrap_r ? '0 : base_b;
		start    = (col_a == '0) && (row_a == '0);
		take_key = force_q || (fsk_q >= keyframe_interval);
		key_a    = start ? take_key : key_q;
		pad      = (row_a < (ph - h)) || (col_a >= w);
		raw      = pad ? 24'd0 : s_tdata[23:0];
		addr     = AW'(base_a + BW'(col_a));
		col_n    = col_a + CW'(1);
		row_n    = row_a + RW'(1);
		fend     = (col_n >= pw) && (row_n >= ph);
		base_n   = base_a + BW'(STORE_W);
	end

	// room for this word counted against queue plus stage 1
	assign s_tready = (q_count + Q_CW'(v_s1)) < Q_CW'(Q_DEPTH);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			base_q  <= '0;
			fsk_q   <= '0;
			force_q <= 1'b1;
			key_q   <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				key_q <= key_a;
				if (start) begin
					force_q <= 1'b0;
					fsk_q   <= take_key ? 30'd0 : fsk_q + 30'd1;
				end
				if (col_n >= pw) begin
					col_q <= '0;
					if (row_n >= ph) begin
						row_q  <= '0;
						base_q <= '0;
					end else begin
						row_q  <= row_n;
						base_q <= base_n;
					end
				end else begin
					col_q  <= col_n;
					row_q  <= row_a;
					base_q <= base_a;
				end
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= start;
			key_s1   <= key_a;
			fend_s1  <= fend;
			hdr_s1   <= {compression_level, key_a ? TYPE_KEY : TYPE_DELTA};
			raw_s1   <= raw;
		end
	end

	// previous-frame store, read-before-write at the same address
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_s1   <= mem[addr];
			mem[addr] <= raw;
		end
	end

	assign push             = v_s1;
	assign push_entry.start = start_s1;
	assign push_entry.key   = key_s1;
	assign push_entry.fend  = fend_s1;
	assign push_entry.hdr   = hdr_s1;
	assign push_entry.data  = key_s1 ? raw_s1 :
		{raw_s1[23:16] - prev_s1[23:16],
		 raw_s1[15:8]  - prev_s1[15:8],
		 raw_s1[7:0]   - prev_s1[7:0]};

endmodule
`default_nettype wire

### design/rfde_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfde_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module rfde_queue
	import rfde_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rfde_entry_t   push_entry,
	input  wire logic          pop,
	output logic               head_valid,
	output rfde_entry_t        head,
	output logic [Q_CW-1:0]    count
);

	rfde_entry_t     slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			count_q <= count_q + Q_CW'(push) - Q_CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

### design/rfde_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfde_back
// Serializes each queued pixel into header words (frame start only) and
// colour words; one word per cycle when not stalled; output is registered.
// ----------------------------------------------------------------------------
module rfde_back
	import rfde_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire rfde_entry_t        head,
	output logic                    pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,
	output logic [TUSER_W-1:0]      m_tuser,
	output logic                    m_tlast
);

	typedef enum logic [5:0] {
		SEL_NEW  = 6'b000001,
		SEL_HDR0 = 6'b000010,
		SEL_HDR1 = 6'b000100,
		SEL_RED  = 6'b001000,
		SEL_GRN  = 6'b010000,
		SEL_BLU  = 6'b100000
	} sel_t;

	sel_t               sel_q;
	sel_t               cur, nxt;
	logic               m_tvalid_q;
	logic [7:0]         tdata_q;
	logic [TUSER_W-1:0] tuser_q;
	logic               tlast_q;
	logic               emit;
	logic [7:0]         byte_c;
	logic               hdr_c, fend_c, last_c;
	logic [TUSER_W-1:0] user_c;

	assign emit = head_valid && (!m_tvalid_q || m_tready);
	assign cur  = (sel_q == SEL_NEW) ? (head.start ? SEL_HDR0 : SEL_RED) : sel_q;

	always_comb begin
		byte_c = head.data[7:0];
		hdr_c  = 1'b0;
		last_c = 1'b0;
		nxt    = SEL_NEW;
		case (cur)
			SEL_HDR0: begin
				byte_c = head.hdr;
				hdr_c  = 1'b1;
				nxt    = SEL_HDR1;
			end
			SEL_HDR1: begin
				byte_c = HDR_SECOND;
				hdr_c  = 1'b1;
				nxt    = SEL_RED;
			end
			SEL_RED: begin
				byte_c = head.data[23:16];
				nxt    = SEL_GRN;
			end
			SEL_GRN: begin
				byte_c = head.data[15:8];
				nxt    = SEL_BLU;
			end
			SEL_BLU: begin
				byte_c = head.data[7:0];
				last_c = 1'b1;
				nxt    = SEL_NEW;
			end
			default: begin
				nxt = SEL_NEW;
			end
		endcase
		fend_c          = last_c && head.fend;
		user_c          = '0;
		user_c[TU_HDR]  = hdr_c;
		user_c[TU_KEY]  = head.key;
		user_c[TU_FEND] = fend_c;
	end

	assign pop = emit && last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q      <= SEL_NEW;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				sel_q      <= nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tdata_q <= byte_c;
			tuser_q <= user_c;
			tlast_q <= last_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

endmodule
`default_nettype wire

### design/rfde_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfde_checker
// Port-level checks of the coded output stream, bound to the top level.
// ----------------------------------------------------------------------------
module rfde_checker
	import rfde_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [7:0]         m_tdata,
	input wire logic [TUSER_W-1:0] m_tuser,
	input wire logic               m_tlast
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed under stall");

	// header words never close a pixel
	a_hdr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[TU_HDR] |-> !m_tlast && !m_tuser[TU_FEND])
		else $error("header word flagged last");

	// frame end falls on the last word of a pixel
	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[TU_FEND] |-> m_tlast)
		else $error("frame end without last");

	// keyframe headers carry the keyframe type or the fixed second byte
	a_key_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[TU_HDR] && m_tuser[TU_KEY] |->
			(m_tdata[3:0] == TYPE_KEY) || (m_tdata == HDR_SECOND))
		else $error("keyframe header type mismatch");

endmodule

bind rgb_frame_delta_encoder rfde_checker u_rfde_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

### tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_frame_delta_encoder. Pixel words go in on the
// slave stream. A behavioral predictor mirrors the scan position, the
// keyframe decision and the previous-frame store, and queues the coded words
// that each accepted pixel should produce. Every word taken off the master
// stream is checked against that queue. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
	import rfde_pkg::*;

	localparam int MAX_W        = 512;
	localparam int MAX_H        = 512;
	localparam int STORE_W      = (MAX_W + 3) / 4 * 4;
	localparam int STORE_H      = (MAX_H + 3) / 4 * 4;
	localparam int RANDOM_ITEMS = 370;
	localparam int TAIL_ITEMS   = 60;
	localparam int CYCLE_LIMIT  = 200_000;

	// one expected word on the coded stream
	typedef struct packed {
		logic [7:0] code;
		logic       hdr;
		logic       key;
		logic       fend;
		logic       last;
	} coded_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [29:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // pixel_word
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;   // out_byte
	logic [TUSER_W-1:0] m_tuser;   // is_header, is_keyframe, frame_end
	logic        m_tlast;

	// predictor: register shadows
	logic [9:0]  img_w_reg   = 10'd512;
	logic [9:0]  img_h_reg   = 10'd512;
	logic [29:0] key_gap_reg = 30'd0;
	logic [3:0]  level_reg   = 4'd7;

	// predictor: scan and keyframe state
	int unsigned pos_col          = 0;
	int unsigned pos_row          = 0;
	logic [29:0] deltas_since_key = 30'd0;
	bit          key_pending      = 1'b1;   // first frame after reset is a key
	bit          key_now          = 1'b0;

	// predictor: previous-frame store plus a map of positions ever written
	logic [23:0] stored_rgb [STORE_W*STORE_H];
	bit          pixel_seen [STORE_W*STORE_H];

	coded_word_t coded_due[$];   // expected words, oldest first

	int mismatches  = 0;
	int cycle_count = 0;
	int ready_hold  = 0;
	bit gaps_on     = 1'b1;

	rgb_frame_delta_encoder #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// hard stop if the stream hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// sink backpressure: random low bursts while gaps are enabled
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready   <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 2);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// 0 and out-of-range dimensions as the block sees them
	function automatic int unsigned dim_limit(input logic [9:0] v, input int unsigned maxv);
		if (v == 10'd0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	task automatic push_word(input logic [7:0] code, input logic hdr, fend, last);
		coded_word_t cw;
		cw.code = code;
		cw.hdr  = hdr;
		cw.key  = key_now;
		cw.fend = fend;
		cw.last = last;
		coded_due.push_back(cw);
	endtask

	// Predict the words caused by one accepted pixel and advance the scan.
	task automatic encode_pixel(input logic [31:0] word);
		int unsigned w, h, pw, ph, addr, c;
		logic [23:0] raw, prev;
		logic [7:0]  b;
		logic        fend;
		w  = dim_limit(img_w_reg, MAX_W);
		h  = dim_limit(img_h_reg, MAX_H);
		pw = (w + 3) / 4 * 4;
		ph = (h + 3) / 4 * 4;
		// registers are live: a shrink can push the scan past the frame edge
		if (pos_col >= pw) begin
			pos_col = 0;
			pos_row++;
		end
		if (pos_row >= ph)
			pos_row = 0;
		// frame start: decide key or delta, then two header words
		if (pos_col == 0 && pos_row == 0) begin
			if (key_pending || deltas_since_key >= key_gap_reg) begin
				key_now          = 1'b1;
				deltas_since_key = 30'd0;
				key_pending      = 1'b0;
			end else begin
				key_now          = 1'b0;
				deltas_since_key = deltas_since_key + 30'd1;
			end
			push_word({level_reg, (key_now ? TYPE_KEY : TYPE_DELTA)}, 1'b1, 1'b0, 1'b0);
			push_word(HDR_SECOND, 1'b1, 1'b0, 1'b0);
		end
		// padded rows lead the scan, padded columns trail each row
		raw  = (pos_row < ph - h || pos_col >= w) ? 24'h0 : word[23:0];
		addr = pos_row * STORE_W + pos_col;
		prev = stored_rgb[addr];
		stored_rgb[addr] = raw;
		pixel_seen[addr] = 1'b1;
		fend = (pos_col + 1 >= pw) && (pos_row + 1 >= ph);
		for (c = 0; c < 3; c++) begin
			b = raw[16 - 8*c +: 8];
			if (!key_now)
				b = b - prev[16 - 8*c +: 8];   // wraps mod 256
			push_word(b, 1'b0, fend && c == 2, c == 2);
		end
		pos_col++;
		if (pos_col >= pw) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= ph)
				pos_row = 0;
		end
	endtask

	// A delta frame must never read a store entry nobody wrote. New settings
	// are fine if every position of the padded frame was written already, or
	// if every frame from here on is a key (interval 0 and we sit at a frame
	// start or inside a key frame).
	function automatic bit mode_safe(input logic [9:0] w_reg, h_reg, input logic [29:0] gap);
		int unsigned pw, ph, c, r, x, y;
		bit covered;
		pw = (dim_limit(w_reg, MAX_W) + 3) / 4 * 4;
		ph = (dim_limit(h_reg, MAX_H) + 3) / 4 * 4;
		c  = pos_col;
		r  = pos_row;
		if (c >= pw) begin
			c = 0;
			r++;
		end
		if (r >= ph)
			r = 0;
		covered = 1'b1;
		for (y = 0; y < ph && covered; y++)
			for (x = 0; x < pw && covered; x++)
				if (!pixel_seen[y * STORE_W + x])
					covered = 1'b0;
		return covered || (gap == 30'd0 && ((c == 0 && r == 0) || key_now));
	endfunction

	// hold off the sender until every predicted word is out
	task automatic wait_all_coded;
		s_tvalid <= 1'b0;
		while (coded_due.size() != 0)
			@(posedge clk);
	endtask

	// Idle the block and write all four registers back to back. Unsafe
	// settings fall back to interval 0, or else keep the old size and interval.
	task automatic set_mode(input logic [9:0] w, h, input logic [29:0] gap, input logic [3:0] lvl);
		if (!mode_safe(w, h, gap)) begin
			if (mode_safe(w, h, 30'd0)) begin
				gap = 30'd0;
			end else begin
				w   = img_w_reg;
				h   = img_h_reg;
				gap = key_gap_reg;
			end
		end
		wait_all_coded();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data  <= {20'd0, w};
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data  <= {20'd0, h};
		@(posedge clk);
		cfg_index <= CFG_INTERVAL;
		cfg_data  <= gap;
		@(posedge clk);
		cfg_index <= CFG_LEVEL;
		cfg_data  <= {26'd0, lvl};
		@(posedge clk);
		cfg_we      <= 1'b0;
		img_w_reg   = w;
		img_h_reg   = h;
		key_gap_reg = gap;
		level_reg   = lvl;
	endtask

	// one pixel word across the slave stream, with an optional gap first
	task automatic send_pixel(input logic [31:0] word);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		encode_pixel(word);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// checker: every word taken off the master stream
	always @(posedge clk) begin
		coded_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (coded_due.size() == 0) begin
				$error("out_byte: expected no word, got %0h", m_tdata);
				mismatches++;
			end else begin
				want = coded_due.pop_front();
				check_field("out_byte", want.code, m_tdata);
				check_field("is_header", {7'd0, want.hdr}, {7'd0, m_tuser[TU_HDR]});
				check_field("is_keyframe", {7'd0, want.key}, {7'd0, m_tuser[TU_KEY]});
				check_field("frame_end", {7'd0, want.fend}, {7'd0, m_tuser[TU_FEND]});
				check_field("last", {7'd0, want.last}, {7'd0, m_tlast});
			end
		end
	end

	// Reset register values: 512x512, every frame a key, level 7 in the header.
	task automatic test_reset_defaults;
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h12AB_34CD);
	endtask

	// Width above the maximum and height 0, then the reverse. Mid-frame: the
	// second change pushes the column past the new padded width and wraps.
	task automatic test_dimension_clamp;
		set_mode(10'd1023, 10'd0, 30'd0, 4'd0);
		send_pixel(32'hFFFF_FFFF);   // padded row, word ignored
		send_pixel($urandom);
		set_mode(10'd0, 10'd1023, 30'd0, 4'd0);
		send_pixel(32'hFF00_FF00);
		send_pixel(32'h00FF_00FF);   // padded column
	endtask

	// 3x3 visible in a 4x4 frame: one padded row first, one padded column
	// per row. Finishes the key frame so the whole 4x4 store is written.
	task automatic test_key_frame;
		set_mode(10'd3, 10'd3, 30'd0, 4'd9);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		send_pixel(32'h80FF_0001);
		send_pixel(32'h0180_7F00);
		send_pixel(32'hFF7F_8001);
		send_pixel(32'h00AA_55AA);
		send_pixel(32'h0055_AA55);
		send_pixel($urandom);
	endtask

	// Interval 1 after a key: next frame is delta; level 15 fills the nibble.
	// Stored FF against new 00 wraps; stored 00 against new FF does not.
	task automatic test_delta_frame;
		set_mode(10'd4, 10'd4, 30'd1, 4'd15);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		send_pixel(32'h8080_8080);
		send_pixel(32'h7F7F_7F7F);
		send_pixel(32'h0102_0304);
		send_pixel(32'hFEDC_BA98);
	endtask

	// Random settings per phase, mostly small frames, now and then an
	// oversized or zero dimension. Each phase boundary drains the stream.
	task automatic test_random_frames;
		int          sent;
		int          n;
		logic [9:0]  w, h;
		logic [29:0] gap;
		bit          wide;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wide = 1'b0;
			case ($urandom_range(0, 9))
				0: w = 10'd0;
				1: begin
					w    = 10'($urandom_range(400, 1023));
					wide = 1'b1;
				end
				default: w = 10'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 9))
				0: h = 10'd0;
				1: begin
					h    = 10'($urandom_range(400, 1023));
					wide = 1'b1;
				end
				default: h = 10'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 5))
				0: gap = 30'd0;
				1: gap = 30'h3FFF_FFFF;
				2: gap = 30'($urandom);
				default: gap = 30'($urandom_range(1, 3));
			endcase
			set_mode(w, h, gap, 4'($urandom_range(0, 15)));
			gaps_on = ($urandom_range(0, 3) != 0);
			n = wide ? $urandom_range(1, 8) : $urandom_range(4, 40);
			repeat (n) send_pixel($urandom);
			sent += n;
		end
		gaps_on = 1'b1;
	endtask

	// closing stretch at full rate, no stalls on either side
	task automatic test_streaming_tail;
		set_mode(10'd6, 10'd3, 30'd2, 4'd5);
		gaps_on = 1'b0;
		repeat (TAIL_ITEMS) send_pixel($urandom);
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_WIDTH;
		cfg_data  <= 30'd0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 32'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_dimension_clamp();
		test_key_frame();
		test_delta_frame();
		test_random_frames();
		test_streaming_tail();

		// let the pipeline drain, then watch for stray words
		wait_all_coded();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && coded_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
